// ----- hdl/pet_pkg.sv -----
package pet_pkg;

  // Sizing
  localparam int CHANNELS   = 16;
  localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = 16;

  localparam logic [CNT_W-1:0]  PERIOD_RESET = CNT_W'(500);
  localparam logic [ADDR_W-1:0] LAST_IDX     = ADDR_W'(CHANNELS - 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_CHANGE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_REMOVE = 2'd2
  } req_type_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_FLUSH
  } state_t;

  // One channel entry as held in the state memory
  typedef struct packed {
    logic                  ever;
    logic                  dirty;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      since;
    logic                  armed;
    logic [CNT_W-1:0]      left;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  // One emission waiting for the output register
  typedef struct packed {
    logic [ADDR_W-1:0]     ch;
    logic [VALUE_BITS-1:0] value;
  } emit_t;

endpackage

// ----- hdl/per_channel_event_throttle.sv -----
// Per-channel event throttle with leading and trailing edge. A change
// transaction stores a channel's value and emits it at once when the channel
// never emitted or a full period has passed; otherwise a countdown is armed
// and the latest value goes out when it expires. A tick transaction advances
// all channels in ascending order and may yield up to one result per channel;
// out_last marks the final result of a transaction. All per-channel state sits
// in one memory with a registered read. A change reads, modifies and writes
// back its entry and then flushes the held result; a remove writes the entry
// at once; in a tick the sequencer walks one memory entry per cycle through the
// single read port while no new emission is held up by a stalled output.
// Output back-pressure can stretch a change or a tick.
// period_ticks is written through cfg_wr_en/cfg_period_ticks and resets to 500.
module per_channel_event_throttle (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [3:0]                in_channel,
  input  logic [31:0]               in_new_value,
  input  logic                      cfg_wr_en,
  input  logic [pet_pkg::CNT_W-1:0] cfg_period_ticks,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_channel,
  output logic [31:0]               out_value,
  output logic                      out_last
);
  import pet_pkg::*;

  rd_req_t rd_req;
  wr_req_t wr_req;
  entry_t  rd_data;

  pet_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  pet_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_channel       (in_channel),
    .in_new_value     (in_new_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_period_ticks (cfg_period_ticks),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_value        (out_value),
    .out_last         (out_last),
    .rd_req           (rd_req),
    .wr_req           (wr_req),
    .rd_data          (rd_data)
  );

endmodule

// ----- hdl/pet_store.sv -----
module pet_store (
  input  logic            clk,
  input  logic            rst_n,
  input  pet_pkg::rd_req_t rd_req,
  input  pet_pkg::wr_req_t wr_req,
  output pet_pkg::entry_t  rd_data
);
  import pet_pkg::*;

  entry_t              mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  entry_t              rd_q_r;

  // Mark entries written since reset; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.en) begin
      valid_r[wr_req.addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  // Registered read port; hold data when no read is issued
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_q_r <= valid_r[rd_req.addr] ? mem[rd_req.addr] : '0;
    end
  end

  assign rd_data = rd_q_r;

endmodule

// ----- hdl/pet_core.sv -----
module pet_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [3:0]                in_channel,
  input  logic [31:0]               in_new_value,
  input  logic                      cfg_wr_en,
  input  logic [pet_pkg::CNT_W-1:0] cfg_period_ticks,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_channel,
  output logic [31:0]               out_value,
  output logic                      out_last,
  output pet_pkg::rd_req_t          rd_req,
  output pet_pkg::wr_req_t          wr_req,
  input  pet_pkg::entry_t           rd_data
);
  import pet_pkg::*;

  state_t                state_r, state_nxt;
  req_type_t             op_r, op_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      period_r, period_nxt;
  logic                  pend_v_r, pend_v_nxt;
  emit_t                 pend_r, pend_nxt;
  logic                  out_v_r, out_v_nxt;
  emit_t                 out_r, out_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ch_ok;
  logic                  out_free;

  assign ch_ok    = 32'(in_channel) < 32'(CHANNELS);
  assign out_free = !out_v_r || !out_stall;

  // Sequencer: accept, read-modify-write each entry (a remove only writes), flush the held emission
  always_comb begin
    entry_t         ent;
    logic           emit;
    logic           go;
    logic [CNT_W:0] sum;

    state_nxt    = state_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    val_nxt      = val_r;
    period_nxt   = cfg_wr_en ? cfg_period_ticks : period_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    rd_req       = '0;
    wr_req       = '0;
    ent          = rd_data;
    emit         = 1'b0;
    go           = 1'b0;
    sum          = '0;

    // Drop the output transaction once taken
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_CHANGE: begin
              if (ch_ok) begin
                rd_req    = '{en: 1'b1, addr: ADDR_W'(in_channel)};
                idx_nxt   = ADDR_W'(in_channel);
                val_nxt   = VALUE_BITS'(in_new_value);
                op_nxt    = REQ_CHANGE;
                state_nxt = ST_MOD;
              end
            end
            REQ_TICK: begin
              rd_req    = '{en: 1'b1, addr: '0};
              idx_nxt   = '0;
              op_nxt    = REQ_TICK;
              state_nxt = ST_MOD;
            end
            REQ_REMOVE: begin
              if (ch_ok) begin
                wr_req = '{en: 1'b1, addr: ADDR_W'(in_channel), data: '0};
              end
            end
            default: ;
          endcase
        end
      end

      ST_MOD: begin
        // Modify the entry held on the registered read port
        if (op_r == REQ_CHANGE) begin
          ent.value = val_r;
          ent.dirty = 1'b1;
          if (!rd_data.ever || rd_data.since >= period_r) begin
            ent.since = '0;
            ent.ever  = 1'b1;
            ent.dirty = 1'b0;
            emit      = 1'b1;
          end else if (!rd_data.armed) begin
            ent.armed = 1'b1;
            ent.left  = period_r - rd_data.since;
          end
        end else begin
          if (rd_data.ever) begin
            sum       = {1'b0, rd_data.since} + (CNT_W+1)'(1);
            ent.since = (sum > {1'b0, period_r}) ? period_r : sum[CNT_W-1:0];
          end
          if (rd_data.armed) begin
            if (rd_data.left > CNT_W'(1)) begin
              ent.left = rd_data.left - CNT_W'(1);
            end else begin
              ent.since = '0;
              ent.ever  = 1'b1;
              if (rd_data.dirty) begin
                ent.dirty = 1'b0;
                ent.left  = period_r;
                emit      = 1'b1;
              end else begin
                ent.armed = 1'b0;
                ent.left  = '0;
              end
            end
          end
        end

        // Hold while a new emission has nowhere to go
        go = !emit || !pend_v_r || out_free;
        if (go) begin
          wr_req = '{en: 1'b1, addr: idx_r, data: ent};
          if (emit) begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{ch: idx_r, value: ent.value};
          end
          // Advance the scan; the next entry differs from the one written
          if (op_r == REQ_TICK && idx_r != LAST_IDX) begin
            rd_req  = '{en: 1'b1, addr: idx_r + ADDR_W'(1)};
            idx_nxt = idx_r + ADDR_W'(1);
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // Release the held emission as the final result of the transaction
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      period_r <= PERIOD_RESET;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      period_r <= period_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_v_r;
  assign out_channel = 4'(out_r.ch);
  assign out_value   = 32'(out_r.value);
  assign out_last    = out_last_r;

endmodule

// ----- hdl/pet_chk.sv -----
module pet_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_channel,
  input logic [31:0] out_value,
  input logic        out_last
);
  import pet_pkg::*;

  // Reset leaves no result and an open input
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_channel) && $stable(out_value) && $stable(out_last))
    else $error("stalled output transaction changed");

  // Change and tick keep the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_req_type == REQ_CHANGE || in_req_type == REQ_TICK) |=> in_stall)
    else $error("input open right after change or tick");

  // A non-final result means the transaction is still in progress
  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input open before final result of transaction");

endmodule

bind per_channel_event_throttle pet_chk u_pet_chk (.*);
